// ===== design/tjt_pkg.sv =====
// Package: shared types and codes for the timeout job table.
package tjt_pkg;

    localparam logic [2:0] MODE_SCHED      = 3'd0;
    localparam logic [2:0] MODE_CANCEL     = 3'd1;
    localparam logic [2:0] MODE_REMOVE     = 3'd2;
    localparam logic [2:0] MODE_TICK       = 3'd3;
    localparam logic [2:0] MODE_SET_TIME   = 3'd4;
    localparam logic [2:0] MODE_STOP       = 3'd5;
    localparam logic [2:0] MODE_CANCEL_ALL = 3'd6;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] job_id;
        logic [31:0] user_tag;
        logic [31:0] delay_ms;
        logic [63:0] now_ms;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] fired_id;
        logic [31:0] fired_tag;
        logic [31:0] fired_timeout;
        logic [31:0] early_elapsed;
        logic        last;
    } t_rsp;

    // One memory row: everything per slot except the valid bit.
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] start;
        logic [31:0] timeout;
        logic [31:0] tag;
        logic        armed;
        logic        cancelled;
    } t_slot;

endpackage

// ===== design/tjt_if.sv =====
// Interfaces: request and response channels.
interface tjt_req_if;
    import tjt_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tjt_rsp_if;
    import tjt_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/timeout_job_table_core.sv =====
// Top level: timeout job table with slot memory and a scanning sequencer.
//
//  channel | dir | handshake      | payload
//  i_req   | in  | valid / ready  | mode, job_id, user_tag, delay_ms, now_ms
//  o_rsp   | out | valid / ready  | kind, fired_id, fired_tag, fired_timeout,
//          |     |                | early_elapsed, last
//
// One item at a time; ready stays low until the final result has been taken.
// Cancel, remove, cancel all and tick walk the row memory, each row read and
// then evaluated; a tick while stopped skips the walk. Schedule scans valid
// bits, one a cycle, for the first free slot. Set time, stop and unused codes
// go straight to the final result.
// Valid bits live in flip-flops and clear at reset; the row memory is not
// cleared. Synchronous active-low reset. A stall on the output holds a tick's scan.
module timeout_job_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tjt_req_if.sink   i_req,
    tjt_rsp_if.source o_rsp
);
    import tjt_pkg::*;

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIND  = 3'd1; // search free slot (valid bits)
    localparam logic [2:0] ST_READ  = 3'd2; // row read issued
    localparam logic [2:0] ST_EVAL  = 3'd3; // row data present
    localparam logic [2:0] ST_FINAL = 3'd4; // emit final result

    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rd;

    logic [2:0]           r_st;
    t_req                 r_req;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [31:0]          r_last_id;
    logic [63:0]          r_time;
    logic                 r_running;
    logic [CW-1:0]        r_idx;
    logic                 r_hit;
    logic                 r_ov;
    t_rsp                 r_out;
    logic                 r_fkind_full;

    logic [IW-1:0] w_i;
    assign w_i = r_idx[IW-1:0];

    logic w_slot_free, w_id_match;
    assign w_slot_free = (r_idx < CW'(TABLE_DEPTH)) && !r_valid[w_i];

    // row evaluation
    logic [63:0] w_diff;
    logic        w_exp, w_fire;
    assign w_diff = r_time - r_rd.start;
    assign w_exp  = w_diff >= {32'd0, r_rd.timeout};
    assign w_fire = r_valid[w_i] && (w_exp || r_rd.cancelled);
    assign w_id_match = r_valid[w_i] && (r_rd.id == r_req.job_id);

    assign i_req.ready = (r_st == ST_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_out;

    logic w_out_free;
    assign w_out_free = !r_ov || o_rsp.ready;

    // a result is loaded into the output register this cycle
    logic w_emit;
    assign w_emit = w_out_free &&
                    (((r_st == ST_EVAL) && (r_req.mode == MODE_TICK) &&
                      w_fire && r_rd.armed) ||
                     (r_st == ST_FINAL));

    // final result fields
    logic [1:0]  w_fin_kind;
    logic [31:0] w_fin_id;
    always_comb begin
        w_fin_kind = KIND_ACK;
        w_fin_id   = '0;
        case (r_req.mode)
            MODE_TICK: w_fin_kind = KIND_DONE;
            MODE_SCHED: begin
                if (r_fkind_full)
                    w_fin_kind = KIND_FULL;
                else
                    w_fin_id = r_last_id;
            end
            MODE_CANCEL, MODE_REMOVE: w_fin_id = r_req.job_id;
            default: w_fin_kind = KIND_ACK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ST_READ)
            r_rd <= r_mem[w_i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_valid   <= '0;
            r_last_id <= '0;
            r_time    <= '0;
            r_running <= 1'b1;
            r_ov      <= 1'b0;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_fkind_full <= 1'b0;
        end else begin
            r_ov <= w_emit || (r_ov && !o_rsp.ready);
            case (r_st)
                ST_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.data;
                        r_idx <= '0;
                        r_hit <= 1'b0;
                        r_fkind_full <= 1'b0;
                        case (i_req.data.mode)
                            MODE_TICK: begin
                                r_time <= i_req.data.now_ms;
                                r_st   <= r_running ? ST_READ : ST_FINAL;
                            end
                            MODE_SET_TIME: begin
                                r_time <= i_req.data.now_ms;
                                r_st   <= ST_FINAL;
                            end
                            MODE_STOP: begin
                                r_valid   <= '0;
                                r_running <= 1'b0;
                                r_st      <= ST_FINAL;
                            end
                            MODE_SCHED:  r_st <= ST_FIND;
                            MODE_CANCEL, MODE_REMOVE, MODE_CANCEL_ALL: r_st <= ST_READ;
                            default:     r_st <= ST_FINAL;
                        endcase
                    end
                end
                ST_FIND: begin
                    // free-slot search over valid bits, one per cycle
                    if (r_idx == CW'(TABLE_DEPTH)) begin
                        r_fkind_full <= 1'b1;
                        r_st <= ST_FINAL;
                    end else if (w_slot_free) begin
                        r_mem[w_i] <= '{id: r_last_id + 32'd1, start: r_time,
                                        timeout: r_req.delay_ms, tag: r_req.user_tag,
                                        armed: 1'b1, cancelled: 1'b0};
                        r_valid[w_i] <= 1'b1;
                        r_last_id <= r_last_id + 32'd1;
                        r_st <= ST_FINAL;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                ST_READ: begin
                    if (r_idx == CW'(TABLE_DEPTH))
                        r_st <= ST_FINAL;
                    else
                        r_st <= ST_EVAL;
                end
                ST_EVAL: begin
                    if (r_req.mode == MODE_TICK) begin
                        if (w_fire && r_rd.armed) begin
                            if (w_out_free) begin
                                r_out <= '{kind: KIND_FIRED, fired_id: r_rd.id,
                                           fired_tag: r_rd.tag,
                                           fired_timeout: r_rd.timeout,
                                           early_elapsed: w_exp ? 32'd0 : w_diff[31:0],
                                           last: 1'b0};
                                r_valid[w_i] <= 1'b0;
                                r_idx <= r_idx + CW'(1);
                                r_st  <= ST_READ;
                            end
                        end else begin
                            if (w_fire)
                                r_valid[w_i] <= 1'b0;
                            r_idx <= r_idx + CW'(1);
                            r_st  <= ST_READ;
                        end
                    end else if (r_req.mode == MODE_CANCEL_ALL) begin
                        if (r_valid[w_i])
                            r_mem[w_i] <= '{id: r_rd.id, start: r_rd.start,
                                            timeout: r_rd.timeout, tag: r_rd.tag,
                                            armed: r_rd.armed, cancelled: 1'b1};
                        r_idx <= r_idx + CW'(1);
                        r_st  <= ST_READ;
                    end else begin
                        // cancel / remove: first matching slot only
                        if (!r_hit && w_id_match) begin
                            r_mem[w_i] <= '{id: r_rd.id, start: r_rd.start,
                                            timeout: r_rd.timeout, tag: r_rd.tag,
                                            armed: r_rd.armed &&
                                                   (r_req.mode != MODE_REMOVE),
                                            cancelled: 1'b1};
                            r_hit <= 1'b1;
                        end
                        r_idx <= r_idx + CW'(1);
                        r_st  <= ST_READ;
                    end
                end
                ST_FINAL: begin
                    if (w_out_free) begin
                        r_out <= '{kind: w_fin_kind, fired_id: w_fin_id,
                                   fired_tag: 32'd0, fired_timeout: 32'd0,
                                   early_elapsed: 32'd0, last: 1'b1};
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== design/tjt_checker.sv =====
// Checker: port-level properties of the timeout job table, bound to the top.
module tjt_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic [1:0] rsp_kind,
    input logic rsp_last,
    input logic [31:0] rsp_early
);
    import tjt_pkg::*;

    // a fired result is never the last one
    a_fired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_kind == KIND_FIRED |-> !rsp_last)
        else $error("fired result marked last");

    // non-fired results are last
    a_other_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_kind != KIND_FIRED |-> rsp_last)
        else $error("final result not marked last");

    // early elapsed only on fired results
    a_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp_kind != KIND_FIRED |-> rsp_early == 32'd0)
        else $error("early elapsed on non-fired result");

    // no new item while a result waits
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready)
        else $error("ready while output pending");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind))
        else $error("stalled result changed");

endmodule

bind timeout_job_table_core tjt_checker u_tjt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .req_valid(i_req.valid),
    .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid),
    .rsp_ready(o_rsp.ready),
    .rsp_kind (o_rsp.data.kind),
    .rsp_last (o_rsp.data.last),
    .rsp_early(o_rsp.data.early_elapsed)
);
